// ===== rtl/cubic_bezier_split_top_assert.svh =====
// Assertion macros used by the block's checker.
`ifndef CUBIC_BEZIER_SPLIT_TOP_ASSERT_SVH
`define CUBIC_BEZIER_SPLIT_TOP_ASSERT_SVH

// Same-cycle implication.
`define CBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cubic_bezier_split assertion failed");

// Next-cycle implication.
`define CBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cubic_bezier_split assertion failed");

`endif

// ===== rtl/cbs_pkg.sv =====
package cbs_pkg;

   // Control point mode of a segment or half.
   typedef logic [1:0] mode_type;

   localparam mode_type MODE_FREE   = 2'd0;  // both controls free
   localparam mode_type MODE_FIX_C1 = 2'd1;  // first control sits on the start
   localparam mode_type MODE_FIX_C2 = 2'd2;  // second control sits on the end

endpackage

// ===== rtl/cubic_bezier_split_top.sv =====
// Cubic Bezier splitter (de Casteljau subdivision). Each input transaction
// carries one cubic segment (start, two controls, end) in signed fixed point
// with 16 fraction bits, a split parameter t with T_FRAC_BITS fraction bits
// (2^T_FRAC_BITS is 1.0) and a control mode. For every segment the block
// returns two result transactions in order: the left half (first control,
// second control, split point) and then the right half (first control,
// second control, original end) with rsp_right_half set, which also marks
// the last transaction of the run. Every interpolation is
// a + floor((b - a) * t / 2^T_FRAC_BITS) and never overflows. Mode 1 forces
// the first control onto the start, mode 2 forces the second control onto
// the end, mode 3 acts as mode 0; the left half reports mode 1 or 0 and the
// right half mode 2 or 0. A segment whose t exceeds 1.0 is accepted and
// dropped without results. Timing: a ten-stage pipeline (three interpolation
// levels, each subtract / multiply / add, behind an input register) accepts
// one segment per cycle while no stage is stalled and feeds an output
// register, which presents the left half and then the right half. The result
// port delivers one half per cycle while rsp_ready is high, so with no
// backpressure the sustained segment rate is set by the two halves sharing
// the single result port. Backpressure stalls only the stages that hold data;
// empty stages keep filling.
module cubic_bezier_split_top #(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // segment input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_ctrl1_x,
   input  logic signed [COORD_BITS-1:0]  req_ctrl1_y,
   input  logic signed [COORD_BITS-1:0]  req_ctrl2_x,
   input  logic signed [COORD_BITS-1:0]  req_ctrl2_y,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   input  logic        [T_FRAC_BITS:0]   req_split_t,
   input  cbs_pkg::mode_type             req_ctrl_mode,
   // half-segment output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_right_half,
   output logic signed [COORD_BITS-1:0]  rsp_out_ctrl1_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_ctrl1_y,
   output logic signed [COORD_BITS-1:0]  rsp_out_ctrl2_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_ctrl2_y,
   output logic signed [COORD_BITS-1:0]  rsp_out_end_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_end_y,
   output cbs_pkg::mode_type             rsp_out_mode
);
   import cbs_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int F  = T_FRAC_BITS;
   localparam int TB = T_FRAC_BITS + 1;       // t width
   localparam int DB = COORD_BITS + 1;        // difference width
   localparam int PB = DB + TB + 1;           // product width (t zero-extended)
   localparam int NS = 10;                    // pipeline stages
   localparam logic [TB-1:0] T_ONE = {1'b1, {F{1'b0}}};

   // Stage valid bits and per-stage ready (stage may load this cycle).
   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;

   // Output holding register: both halves of one segment.
   logic          o_valid_ff;
   logic          o_right_ff;

   // A stage loads when it is empty or its content moves on. The output
   // register frees up once the right half has gone. Walk from the output
   // back so each stage sees the ready of the one after it.
   always_comb begin
      rdy[NS] = ~o_valid_ff | (rsp_ready & o_right_ff);
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = ~v_ff[i] | rdy[i+1];
      end
   end

   assign req_ready = rdy[0];

   // Valid bits travel with the data. Drop segments whose t is above one.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_valid & (req_split_t <= T_ONE);
         end
         for (int i = 1; i < NS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Index [k][j]: point or term k, lane j (0 = x, 1 = y).

   // Stage 0: input register with control-mode substitution.
   logic signed [CB-1:0] s0_p_ff [4][2];
   logic        [TB-1:0] t_ff    [NS];
   mode_type             mode_ff [NS];

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_p_ff[0][0] <= req_start_x;
         s0_p_ff[0][1] <= req_start_y;
         s0_p_ff[1][0] <= (req_ctrl_mode == MODE_FIX_C1) ? req_start_x : req_ctrl1_x;
         s0_p_ff[1][1] <= (req_ctrl_mode == MODE_FIX_C1) ? req_start_y : req_ctrl1_y;
         s0_p_ff[2][0] <= (req_ctrl_mode == MODE_FIX_C2) ? req_end_x : req_ctrl2_x;
         s0_p_ff[2][1] <= (req_ctrl_mode == MODE_FIX_C2) ? req_end_y : req_ctrl2_y;
         s0_p_ff[3][0] <= req_end_x;
         s0_p_ff[3][1] <= req_end_y;
      end
   end

   // t and mode ride along with each segment.
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         t_ff[0]    <= req_split_t;
         // Treat the unused code as free.
         mode_ff[0] <= (req_ctrl_mode == MODE_FIX_C1 || req_ctrl_mode == MODE_FIX_C2) ?
                       req_ctrl_mode : MODE_FREE;
      end
      for (int i = 1; i < NS; i++) begin
         if (rdy[i]) begin
            t_ff[i]    <= t_ff[i-1];
            mode_ff[i] <= mode_ff[i-1];
         end
      end
   end

   // Level 1: q1 = lerp(p0,p1), r = lerp(p1,p2), s = lerp(p2,p3).
   logic signed [CB-1:0] s1_a_ff  [3][2];
   logic signed [DB-1:0] s1_d_ff  [3][2];
   logic signed [CB-1:0] s1_p3_ff [2];
   logic signed [CB-1:0] s2_a_ff  [3][2];
   logic signed [PB-1:0] s2_m_ff  [3][2];
   logic signed [CB-1:0] s2_p3_ff [2];
   logic signed [CB-1:0] s3_l_ff  [3][2];   // q1, r, s
   logic signed [CB-1:0] s3_p3_ff [2];

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         if (rdy[1]) begin
            for (int k = 0; k < 3; k++) begin
               s1_a_ff[k][j] <= s0_p_ff[k][j];
               s1_d_ff[k][j] <= DB'(s0_p_ff[k+1][j]) - DB'(s0_p_ff[k][j]);
            end
            s1_p3_ff[j] <= s0_p_ff[3][j];
         end
         if (rdy[2]) begin
            for (int k = 0; k < 3; k++) begin
               s2_a_ff[k][j] <= s1_a_ff[k][j];
               s2_m_ff[k][j] <= PB'(s1_d_ff[k][j]) * PB'($signed({1'b0, t_ff[1]}));
            end
            s2_p3_ff[j] <= s1_p3_ff[j];
         end
         if (rdy[3]) begin
            for (int k = 0; k < 3; k++) begin
               s3_l_ff[k][j] <= s2_a_ff[k][j] + s2_m_ff[k][j][CB-1+F:F];
            end
            s3_p3_ff[j] <= s2_p3_ff[j];
         end
      end
   end

   // Level 2: q2 = lerp(q1,r), r1 = lerp(r,s). Carry q1, s, p3 for output.
   logic signed [CB-1:0] s4_a_ff  [2][2];
   logic signed [DB-1:0] s4_d_ff  [2][2];
   logic signed [CB-1:0] s4_k_ff  [3][2];   // kept: q1, s, p3
   logic signed [CB-1:0] s5_a_ff  [2][2];
   logic signed [PB-1:0] s5_m_ff  [2][2];
   logic signed [CB-1:0] s5_k_ff  [3][2];
   logic signed [CB-1:0] s6_l_ff  [2][2];   // q2, r1
   logic signed [CB-1:0] s6_k_ff  [3][2];

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         if (rdy[4]) begin
            for (int k = 0; k < 2; k++) begin
               s4_a_ff[k][j] <= s3_l_ff[k][j];
               s4_d_ff[k][j] <= DB'(s3_l_ff[k+1][j]) - DB'(s3_l_ff[k][j]);
            end
            s4_k_ff[0][j] <= s3_l_ff[0][j];
            s4_k_ff[1][j] <= s3_l_ff[2][j];
            s4_k_ff[2][j] <= s3_p3_ff[j];
         end
         if (rdy[5]) begin
            for (int k = 0; k < 2; k++) begin
               s5_a_ff[k][j] <= s4_a_ff[k][j];
               s5_m_ff[k][j] <= PB'(s4_d_ff[k][j]) * PB'($signed({1'b0, t_ff[4]}));
            end
            for (int k = 0; k < 3; k++) begin
               s5_k_ff[k][j] <= s4_k_ff[k][j];
            end
         end
         if (rdy[6]) begin
            for (int k = 0; k < 2; k++) begin
               s6_l_ff[k][j] <= s5_a_ff[k][j] + s5_m_ff[k][j][CB-1+F:F];
            end
            for (int k = 0; k < 3; k++) begin
               s6_k_ff[k][j] <= s5_k_ff[k][j];
            end
         end
      end
   end

   // Level 3: m = lerp(q2,r1).
   logic signed [DB-1:0] s7_d_ff  [2];
   logic signed [CB-1:0] s7_k_ff  [5][2];   // kept: q1, s, p3, q2, r1
   logic signed [PB-1:0] s8_m_ff  [2];
   logic signed [CB-1:0] s8_k_ff  [5][2];
   logic signed [CB-1:0] s9_m_ff  [2];
   logic signed [CB-1:0] s9_k_ff  [5][2];

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         if (rdy[7]) begin
            s7_d_ff[j] <= DB'(s6_l_ff[1][j]) - DB'(s6_l_ff[0][j]);
            for (int k = 0; k < 3; k++) begin
               s7_k_ff[k][j] <= s6_k_ff[k][j];
            end
            s7_k_ff[3][j] <= s6_l_ff[0][j];
            s7_k_ff[4][j] <= s6_l_ff[1][j];
         end
         if (rdy[8]) begin
            s8_m_ff[j] <= PB'(s7_d_ff[j]) * PB'($signed({1'b0, t_ff[7]}));
            for (int k = 0; k < 5; k++) begin
               s8_k_ff[k][j] <= s7_k_ff[k][j];
            end
         end
         if (rdy[9]) begin
            s9_m_ff[j] <= s8_k_ff[3][j] + s8_m_ff[j][CB-1+F:F];
            for (int k = 0; k < 5; k++) begin
               s9_k_ff[k][j] <= s8_k_ff[k][j];
            end
         end
      end
   end

   // Output register: hold both halves, send left then right.
   logic signed [CB-1:0] o_m_ff [2];
   logic signed [CB-1:0] o_k_ff [5][2];
   mode_type             o_mode_ff;
   logic                 o_load;

   assign o_load = v_ff[NS-1] & rdy[NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         o_right_ff <= 1'b0;
      end else if (o_load) begin
         o_valid_ff <= 1'b1;
         o_right_ff <= 1'b0;
      end else if (o_valid_ff && rsp_ready) begin
         // Advance to the right half, or drop the segment once it has gone.
         o_valid_ff <= ~o_right_ff;
         o_right_ff <= ~o_right_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_m_ff    <= s9_m_ff;
         o_k_ff    <= s9_k_ff;
         o_mode_ff <= mode_ff[NS-1];
      end
   end

   // Left half: (q1, q2, m). Right half: (r1, s, p3).
   assign rsp_valid       = o_valid_ff;
   assign rsp_right_half  = o_right_ff;
   assign rsp_out_ctrl1_x = o_right_ff ? o_k_ff[4][0] : o_k_ff[0][0];
   assign rsp_out_ctrl1_y = o_right_ff ? o_k_ff[4][1] : o_k_ff[0][1];
   assign rsp_out_ctrl2_x = o_right_ff ? o_k_ff[1][0] : o_k_ff[3][0];
   assign rsp_out_ctrl2_y = o_right_ff ? o_k_ff[1][1] : o_k_ff[3][1];
   assign rsp_out_end_x   = o_right_ff ? o_k_ff[2][0] : o_m_ff[0];
   assign rsp_out_end_y   = o_right_ff ? o_k_ff[2][1] : o_m_ff[1];

   always_comb begin
      if (o_right_ff) begin
         rsp_out_mode = (o_mode_ff == MODE_FIX_C2) ? MODE_FIX_C2 : MODE_FREE;
      end else begin
         rsp_out_mode = (o_mode_ff == MODE_FIX_C1) ? MODE_FIX_C1 : MODE_FREE;
      end
   end

endmodule

// ===== rtl/cbs_checker.sv =====
`include "cubic_bezier_split_top_assert.svh"

module cbs_checker #(
   parameter int COORD_BITS  = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_right_half,
   input logic signed [COORD_BITS-1:0]  rsp_out_ctrl1_x,
   input logic signed [COORD_BITS-1:0]  rsp_out_end_x,
   input cbs_pkg::mode_type             rsp_out_mode
);
   import cbs_pkg::*;

   logic [2*COORD_BITS+2:0] rsp_payload;
   logic                    rsp_stalled;
   logic                    left_taken;
   logic                    mode_ok;

   assign rsp_payload = {rsp_right_half, rsp_out_ctrl1_x, rsp_out_end_x, rsp_out_mode};
   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign left_taken  = rsp_valid && rsp_ready && !rsp_right_half;
   assign mode_ok     = rsp_right_half ?
                        (rsp_out_mode == MODE_FREE || rsp_out_mode == MODE_FIX_C2) :
                        (rsp_out_mode == MODE_FREE || rsp_out_mode == MODE_FIX_C1);

   // Hold a stalled result steady.
   `CBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

   // A left half is always followed at once by its right half.
   `CBS_ASSERT_NEXT(a_right_follows, clock, reset, left_taken, rsp_valid && rsp_right_half)

   // Left halves report free or fixed first control; right halves free or fixed second.
   `CBS_ASSERT_NOW(a_mode_per_half, clock, reset, rsp_valid, mode_ok)

   // Reset empties the result port.
   `CBS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind cubic_bezier_split_top cbs_checker #(
   .COORD_BITS  (COORD_BITS)
) u_cbs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_right_half  (rsp_right_half),
   .rsp_out_ctrl1_x (rsp_out_ctrl1_x),
   .rsp_out_end_x   (rsp_out_end_x),
   .rsp_out_mode    (rsp_out_mode)
);

// ===== verif/cubic_bezier_split_top_test.sv =====
`timescale 1ns / 1ps

module cubic_bezier_split_top_test;
   import cbs_pkg::*;

   localparam int COORD_W = 32;
   localparam int T_FRAC  = 16;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 30;   // pipeline is eleven deep; allow margin

   localparam logic [T_FRAC:0] T_ZERO = '0;
   localparam logic [T_FRAC:0] T_HALF = 17'h08000;
   localparam logic [T_FRAC:0] T_ONE  = 17'h10000;
   localparam logic [T_FRAC:0] T_TOP  = 17'h1ffff;     // every bit set, above one

   // Mode 3 has no name in the package; it behaves as the free mode.
   localparam mode_type MODE_SPARE = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type C_MAX  = 32'sh7fffffff;
   localparam coord_type C_MIN  = 32'sh80000000;
   localparam coord_type C_ZERO = 32'sh00000000;

   typedef struct packed {
      coord_type        p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
      logic [T_FRAC:0]  t;
      mode_type         mode;
   } segment_type;

   typedef struct packed {
      logic       right;
      coord_type  c1x, c1y, c2x, c2y, ex, ey;
      mode_type   mode;
   } half_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   coord_type        req_start_x, req_start_y, req_ctrl1_x, req_ctrl1_y;
   coord_type        req_ctrl2_x, req_ctrl2_y, req_end_x, req_end_y;
   logic [T_FRAC:0]  req_split_t;
   mode_type         req_ctrl_mode;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_right_half;
   coord_type        rsp_out_ctrl1_x, rsp_out_ctrl1_y, rsp_out_ctrl2_x, rsp_out_ctrl2_y;
   coord_type        rsp_out_end_x, rsp_out_end_y;
   mode_type         rsp_out_mode;

   half_type  expected_halves[$];
   int        fail_count;
   bit        no_idle;      // set during the burst test: both sides run flat out

   cubic_bezier_split_top #(
      .COORD_BITS  (COORD_W),
      .T_FRAC_BITS (T_FRAC)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_ctrl1_x     (req_ctrl1_x),
      .req_ctrl1_y     (req_ctrl1_y),
      .req_ctrl2_x     (req_ctrl2_x),
      .req_ctrl2_y     (req_ctrl2_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_split_t     (req_split_t),
      .req_ctrl_mode   (req_ctrl_mode),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_right_half  (rsp_right_half),
      .rsp_out_ctrl1_x (rsp_out_ctrl1_x),
      .rsp_out_ctrl1_y (rsp_out_ctrl1_y),
      .rsp_out_ctrl2_x (rsp_out_ctrl2_x),
      .rsp_out_ctrl2_y (rsp_out_ctrl2_y),
      .rsp_out_end_x   (rsp_out_end_x),
      .rsp_out_end_y   (rsp_out_end_y),
      .rsp_out_mode    (rsp_out_mode)
   );

   always #5 clock = ~clock;

   // Interpolate a + floor((b - a) * t / 2^T_FRAC). The difference needs 33
   // bits and the product 50, so 64-bit signed math is exact, and the
   // arithmetic shift gives the floor toward minus infinity.
   function automatic longint lerp_floor(longint a, longint b, longint t);
      longint prod;
      prod = (b - a) * t;
      return a + (prod >>> T_FRAC);
   endfunction

   // Work out both halves of one accepted segment and queue them in the
   // order the block must return them. A parameter above one yields nothing.
   task automatic split_segment(input segment_type s);
      longint p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y, t;
      longint q1x, q1y, rx, ry, sx, sy, q2x, q2y, r1x, r1y, mx, my;
      mode_type m;
      half_type h;
      p0x = longint'(s.p0x); p0y = longint'(s.p0y);
      p1x = longint'(s.p1x); p1y = longint'(s.p1y);
      p2x = longint'(s.p2x); p2y = longint'(s.p2y);
      p3x = longint'(s.p3x); p3y = longint'(s.p3y);
      t = longint'(s.t);
      m = (s.mode == MODE_SPARE) ? MODE_FREE : s.mode;
      if (s.t > T_ONE) return;
      // Pin the fixed control onto its neighboring end point.
      if (m == MODE_FIX_C1) begin
         p1x = p0x;
         p1y = p0y;
      end
      if (m == MODE_FIX_C2) begin
         p2x = p3x;
         p2y = p3y;
      end
      q1x = lerp_floor(p0x, p1x, t);  q1y = lerp_floor(p0y, p1y, t);
      rx  = lerp_floor(p1x, p2x, t);  ry  = lerp_floor(p1y, p2y, t);
      sx  = lerp_floor(p2x, p3x, t);  sy  = lerp_floor(p2y, p3y, t);
      q2x = lerp_floor(q1x, rx, t);   q2y = lerp_floor(q1y, ry, t);
      r1x = lerp_floor(rx, sx, t);    r1y = lerp_floor(ry, sy, t);
      mx  = lerp_floor(q2x, r1x, t);  my  = lerp_floor(q2y, r1y, t);
      h.right = 1'b0;
      h.c1x = coord_type'(q1x);  h.c1y = coord_type'(q1y);
      h.c2x = coord_type'(q2x);  h.c2y = coord_type'(q2y);
      h.ex  = coord_type'(mx);   h.ey  = coord_type'(my);
      h.mode = (m == MODE_FIX_C1) ? MODE_FIX_C1 : MODE_FREE;
      expected_halves.push_back(h);
      h.right = 1'b1;
      h.c1x = coord_type'(r1x);  h.c1y = coord_type'(r1y);
      h.c2x = coord_type'(sx);   h.c2y = coord_type'(sy);
      h.ex  = coord_type'(p3x);  h.ey  = coord_type'(p3y);
      h.mode = (m == MODE_FIX_C2) ? MODE_FIX_C2 : MODE_FREE;
      expected_halves.push_back(h);
   endtask

   // Offer one segment on the request channel. Change inputs on the falling
   // edge, hold them until a rising edge sees valid and ready together, then
   // predict the halves. The next call may lower valid for an idle gap; the wrap-up lowers it.
   task automatic send_segment(input segment_type s);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_start_x   <= s.p0x;  req_start_y <= s.p0y;
      req_ctrl1_x   <= s.p1x;  req_ctrl1_y <= s.p1y;
      req_ctrl2_x   <= s.p2x;  req_ctrl2_y <= s.p2y;
      req_end_x     <= s.p3x;  req_end_y   <= s.p3y;
      req_split_t   <= s.t;
      req_ctrl_mode <= s.mode;
      do @(posedge clock); while (!req_ready);
      split_segment(s);
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(0, 9))
         0: return C_MAX;
         1: return C_MIN;
         2: return coord_type'($urandom_range(0, 2000)) - coord_type'(1000);
         3: return coord_type'($urandom_range(0, 32'h000fffff)) - coord_type'(32'h00080000);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Mostly a legal parameter with the end points well represented; a few
   // parameters above one exercise the drop path.
   function automatic logic [T_FRAC:0] random_t();
      case ($urandom_range(0, 19))
         0: return T_ZERO;
         1: return T_ONE;
         2: return T_HALF;
         3: return (T_FRAC+1)'($urandom_range(32'h10001, 32'h1ffff));
         default: return (T_FRAC+1)'($urandom_range(0, 32'h10000));
      endcase
   endfunction

   function automatic segment_type random_segment();
      segment_type s;
      s.p0x = random_coord();  s.p0y = random_coord();
      s.p1x = random_coord();  s.p1y = random_coord();
      s.p2x = random_coord();  s.p2y = random_coord();
      s.p3x = random_coord();  s.p3y = random_coord();
      s.t    = random_t();
      s.mode = mode_type'($urandom_range(0, 3));
      return s;
   endfunction

   // Compare one field, report the first few mismatches with both values.
   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
      end
   endtask

   // Check every result transaction against the oldest pending half.
   always @(posedge clock) begin
      half_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_halves.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result transaction at %0t", $realtime);
         end else begin
            want = expected_halves.pop_front();
            check_field("right_half", longint'(want.right), longint'(rsp_right_half));
            check_field("out_ctrl1_x", longint'(want.c1x), longint'(rsp_out_ctrl1_x));
            check_field("out_ctrl1_y", longint'(want.c1y), longint'(rsp_out_ctrl1_y));
            check_field("out_ctrl2_x", longint'(want.c2x), longint'(rsp_out_ctrl2_x));
            check_field("out_ctrl2_y", longint'(want.c2y), longint'(rsp_out_ctrl2_y));
            check_field("out_end_x", longint'(want.ex), longint'(rsp_out_end_x));
            check_field("out_end_y", longint'(want.ey), longint'(rsp_out_end_y));
            check_field("out_mode", longint'(want.mode), longint'(rsp_out_mode));
         end
      end
   end

   // Stall the result side about 8 percent of the time, except during the burst.
   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 8);
   end

   // Extremes of every coordinate, the parameter at zero, half and one, each
   // mode including the spare code, and parameters above one that get dropped.
   task automatic test_directed();
      segment_type s;
      send_segment('{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, T_ZERO, MODE_FREE});
      send_segment('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, T_ONE, MODE_FREE});
      send_segment('{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                     T_HALF, MODE_FREE});
      send_segment('{C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, T_HALF, MODE_FREE});
      send_segment('{C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, 17'd1, MODE_FREE});
      send_segment('{C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                     17'h0ffff, MODE_FREE});
      send_segment('{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, T_ONE, MODE_FIX_C1});
      send_segment('{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, T_ONE, MODE_FIX_C2});
      send_segment('{C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, T_ZERO, MODE_SPARE});
      // Parameter above one: accepted and dropped without results.
      send_segment('{C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN,
                     17'h10001, MODE_FREE});
      send_segment('{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, T_TOP, MODE_SPARE});
      // Small curves: negative differences exercise the floor.
      send_segment('{32'sd0, 32'sd0, -32'sd3, 32'sd5, 32'sd7, -32'sd1, -32'sd2, 32'sd9,
                     17'd21845, MODE_FREE});
      send_segment('{32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd131072,
                     -32'sd131072, -32'sd1, 32'sd1, 17'd43690, MODE_FIX_C1});
      // Each mode with random coordinates at a few parameters.
      for (int m = 0; m < 4; m++) begin
         s = random_segment();
         s.mode = mode_type'(m);
         s.t = (m % 2) ? T_HALF : T_ONE;
         send_segment(s);
         s = random_segment();
         s.mode = mode_type'(m);
         s.t = (T_FRAC+1)'($urandom_range(1, 32'hffff));
         send_segment(s);
      end
   endtask

   // Broad random segments under random idling on both sides.
   task automatic test_random_segments(input int count);
      segment_type s;
      int sent;
      sent = 0;
      while (sent < count) begin
         s = random_segment();
         send_segment(s);
         if (s.t <= T_ONE) sent++;
      end
   endtask

   // Back-to-back segments with both sides always ready.
   task automatic test_burst(input int count);
      no_idle = 1'b1;
      repeat (count) send_segment(random_segment());
      no_idle = 1'b0;
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_start_x   = '0;  req_start_y = '0;
      req_ctrl1_x   = '0;  req_ctrl1_y = '0;
      req_ctrl2_x   = '0;  req_ctrl2_y = '0;
      req_end_x     = '0;  req_end_y   = '0;
      req_split_t   = '0;
      req_ctrl_mode = MODE_FREE;
      no_idle       = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_segments(1030);
      test_burst(500);

      // Drop valid once the last transaction is taken, then drain.
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_halves.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_halves.size() == 0) begin
         $display("** cubic_bezier_split_top: PASSED **");
      end else begin
         $display("** cubic_bezier_split_top: FAILED **");
      end
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("** cubic_bezier_split_top: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cbs_pkg.sv
rtl/cubic_bezier_split_top.sv
rtl/cbs_checker.sv
verif/cubic_bezier_split_top_test.sv
